FILE: rtl/wavf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package wavf_pkg;
   localparam int unsigned HdrLen = 44;
   localparam logic [0:0] CsrRate  = 1'b0;
   localparam logic [0:0] CsrTotal = 1'b1;

   // Byte of the canonical header at position idx.
   function automatic logic [7:0] hdr_byte(input logic [5:0] idx,
                                           input logic [30:0] rate,
                                           input logic [30:0] total);
      logic [31:0] data_len;
      logic [31:0] chunk_len;
      logic [31:0] rate_x2;
      logic [7:0]  b;
      data_len  = {total, 1'b0};
      chunk_len = data_len + 32'd36;
      rate_x2   = {rate, 1'b0};
      case (idx)
         6'd0:  b = 8'h52;
         6'd1:  b = 8'h49;
         6'd2:  b = 8'h46;
         6'd3:  b = 8'h46;
         6'd4:  b = chunk_len[7:0];
         6'd5:  b = chunk_len[15:8];
         6'd6:  b = chunk_len[23:16];
         6'd7:  b = chunk_len[31:24];
         6'd8:  b = 8'h57;
         6'd9:  b = 8'h41;
         6'd10: b = 8'h56;
         6'd11: b = 8'h45;
         6'd12: b = 8'h66;
         6'd13: b = 8'h6d;
         6'd14: b = 8'h74;
         6'd15: b = 8'h20;
         6'd16: b = 8'd16;
         6'd20: b = 8'd1;
         6'd22: b = 8'd1;
         6'd24: b = rate[7:0];
         6'd25: b = rate[15:8];
         6'd26: b = rate[23:16];
         6'd27: b = {1'b0, rate[30:24]};
         6'd28: b = rate_x2[7:0];
         6'd29: b = rate_x2[15:8];
         6'd30: b = rate_x2[23:16];
         6'd31: b = rate_x2[31:24];
         6'd32: b = 8'd2;
         6'd34: b = 8'd16;
         6'd36: b = 8'h64;
         6'd37: b = 8'h61;
         6'd38: b = 8'h74;
         6'd39: b = 8'h61;
         6'd40: b = data_len[7:0];
         6'd41: b = data_len[15:8];
         6'd42: b = data_len[23:16];
         6'd43: b = data_len[31:24];
         default: b = 8'h00;
      endcase
      return b;
   endfunction
endpackage
`default_nettype wire

FILE: rtl/wavf_quant.sv
`timescale 1ns / 1ps
`default_nettype none
// Float to int16: clip to [-1,1], scale by 32767, round half away from zero; non-finite gives 0.
module wavf_quant (
   input  wire logic [31:0] sample_bits,
   output logic      [15:0] pcm
);
   logic [7:0]  expo;
   logic [23:0] mant;
   logic [47:0] prod;
   logic [5:0]  sh;
   logic [47:0] shifted;
   logic [15:0] mag;

   always_comb begin
      expo = sample_bits[30:23];
      mant = {1'b1, sample_bits[22:0]};
      // |s| = mant * 2^(expo-150); |s|*32767 rounded = floor(mant*32767*2^(e-150)+0.5)
      prod = {24'd0, mant} * 48'd32767;
      sh = 6'd0;
      shifted = 48'd0;
      mag = 16'd0;
      if (expo == 8'hff || expo < 8'd102) begin
         mag = 16'd0;                      // non-finite, zero, or far below half lsb
      end else if (expo >= 8'd127) begin
         mag = 16'd32767;                  // clipped
      end else begin
         sh = 6'(8'd149 - expo);           // shift of 23..47: (150-e)-1
         shifted = prod >> sh;             // keeps one fraction bit
         mag = 16'((shifted + 48'd1) >> 1);
      end
      pcm = sample_bits[31] ? 16'(-mag) : mag;
   end
endmodule
`default_nettype wire

FILE: rtl/wav_mono16_stream_framer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Channel | Dir | tdata                 | tuser / tlast
// req     | in  | [31:0] sample_bits    | -
// rsp     | out | [7:0]  out_byte       | tuser = file_last, tlast = run_last
// csr     | in  | index 1 bit, data 31  | -
// A sample yields 2 bytes, or 46 when it opens a file: one byte per cycle
// at the output register while rsp_tready does not stall it.
// The next sample is taken into the input register as the last byte moves to the output register.
// Reset (synchronous, high) restores rate 44100, total 1, position 0.
// Stalls on rsp_tready hold the byte register; nothing is dropped.
module wav_mono16_stream_framer_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // sample_bits
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // out_byte
   output logic             rsp_tlast,   // run_last
   output logic             rsp_tuser,   // file_last
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [30:0] csr_data
);
   logic [30:0] rate_ff, total_ff, done_ff, done_in;
   logic        hold_ff;          // sample held in input register
   logic [31:0] smp_ff;
   logic        hdr_ff;           // held sample starts a file
   logic        ends_ff;
   logic [5:0]  pos_ff, pos_in;   // byte position within the held run
   logic [15:0] pcm;
   logic        out_ok, take, last_byte, accept;
   logic [7:0]  byte_val;
   logic [5:0]  first_data;

   assign csr_ready = 1'b1;

   wavf_quant u_quant (.sample_bits(smp_ff), .pcm(pcm));

   assign out_ok     = !rsp_tvalid || rsp_tready;
   assign take       = hold_ff && out_ok;
   assign first_data = hdr_ff ? 6'(wavf_pkg::HdrLen) : 6'd0;
   assign last_byte  = pos_ff == first_data + 6'd1;
   assign req_tready = !hold_ff || (take && last_byte);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      if (pos_ff < first_data)
         byte_val = wavf_pkg::hdr_byte(pos_ff, rate_ff, total_ff);
      else if (pos_ff == first_data)
         byte_val = pcm[7:0];
      else
         byte_val = pcm[15:8];
      pos_in  = take ? pos_ff + 6'd1 : pos_ff;
      done_in = done_ff;
      if (accept) begin
         pos_in  = 6'd0;
         done_in = ((32'(done_ff) + 32'd1) >= 32'(total_ff)) ? 31'd0 : done_ff + 31'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff    <= 31'd44100;
         total_ff   <= 31'd1;
         done_ff    <= 31'd0;
         hold_ff    <= 1'b0;
         rsp_tvalid <= 1'b0;
         pos_ff     <= 6'd0;
      end else begin
         if (csr_valid && csr_index == wavf_pkg::CsrRate)  rate_ff  <= csr_data;
         if (csr_valid && csr_index == wavf_pkg::CsrTotal) total_ff <= csr_data;
         done_ff <= done_in;
         pos_ff  <= pos_in;
         if (accept)
            hold_ff <= 1'b1;
         else if (take && last_byte)
            hold_ff <= 1'b0;
         if (take)
            rsp_tvalid <= 1'b1;
         else if (rsp_tready)
            rsp_tvalid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         smp_ff  <= req_tdata;
         hdr_ff  <= done_ff == 31'd0;
         ends_ff <= (32'(done_ff) + 32'd1) >= 32'(total_ff);
      end
      if (take) begin
         rsp_tdata <= byte_val;
         rsp_tlast <= last_byte;
         rsp_tuser <= last_byte && ends_ff;
      end
   end
endmodule
`default_nettype wire

FILE: verif/tb_wav_mono16_stream_framer_top.sv
`timescale 1ns / 1ps
// Stimulus: a short directed pass, then about 130 random samples.
// A local predictor builds each WAV byte from the current rate and total.
// A monitor checks each byte, run_last and file_last against the oldest expected byte.
module tb_wav_mono16_stream_framer_top;

   typedef struct packed {
      logic [7:0] wav_byte;
      logic       run_last;
      logic       file_last;
   } wav_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // sample_bits
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;        // out_byte
   logic        rsp_tlast;        // run_last
   logic        rsp_tuser;        // file_last
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = wavf_pkg::CsrRate;
   logic [30:0] csr_data = '0;

   wav_mono16_stream_framer_top dut (.*);

   always #5 clock = ~clock;

   // Predictor state, kept in step with what the DUT has accepted.
   logic [30:0] rate_q  = 31'd44100;
   logic [30:0] total_q = 31'd1;
   logic [30:0] done_q  = '0;

   logic [31:0]  sample_fifo[$];   // samples waiting for the driver
   wav_byte_type wav_expect[$];    // bytes owed by the DUT
   int          errors = 0;
   int          bytes_seen = 0;
   int          samples_sent = 0;
   int          files_seen = 0;
   int          idle_cycles = 0;
   bit          quiet = 1'b0;     // no idling in the final stretch
   int          src_gap = 0;
   int          snk_gap = 0;

   // Set when req_tready was high at the last rising edge, so the sample on the bus was taken.
   logic req_tready_s = 1'b0;

   // Clip, scale by 32767, round half away from zero. Non-finite gives 0.
   // Subnormals are far below half a step and give 0 as well.
   function automatic logic [15:0] pcm16_of(input logic [31:0] bits);
      logic [63:0] dbits;
      real         v;
      int          q;
      if (bits[30:23] == 8'hff || bits[30:23] == 8'h00) return 16'h0000;
      dbits = {bits[31], 11'(bits[30:23]) + 11'd896, bits[22:0], 29'd0};
      v = $bitstoreal(dbits);
      if (v < -1.0) v = -1.0;
      if (v > 1.0) v = 1.0;
      v = v * 32767.0;
      if (v >= 0.0) q = int'($floor(v + 0.5));
      else q = -int'($floor(-v + 0.5));
      return q[15:0];
   endfunction

   function automatic logic [7:0] le_byte(input logic [31:0] v, input int k);
      return v[8*k +: 8];
   endfunction

   // Expected bytes of one accepted sample, header first when a file opens.
   task automatic predict_sample(input logic [31:0] bits);
      logic [31:0] data_sz;
      logic [31:0] riff_sz;
      logic [31:0] rate32;
      logic [31:0] brate;
      logic [7:0]  hdr[44];
      logic [15:0] pcm;
      bit          ends;
      data_sz = {total_q, 1'b0};
      riff_sz = data_sz + 32'd36;
      rate32  = {1'b0, rate_q};
      brate   = {rate_q, 1'b0};
      if (done_q == 31'd0) begin
         hdr = '{8'h52, 8'h49, 8'h46, 8'h46, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'h57, 8'h41, 8'h56, 8'h45, 8'h66, 8'h6d, 8'h74, 8'h20,
                 8'h10, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h01, 8'h00,
                 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                 8'h02, 8'h00, 8'h10, 8'h00, 8'h64, 8'h61, 8'h74, 8'h61,
                 8'h00, 8'h00, 8'h00, 8'h00};
         for (int k = 0; k < 4; k++) begin
            hdr[4 + k]  = le_byte(riff_sz, k);
            hdr[24 + k] = le_byte(rate32, k);
            hdr[28 + k] = le_byte(brate, k);
            hdr[40 + k] = le_byte(data_sz, k);
         end
         foreach (hdr[k]) wav_expect.push_back('{hdr[k], 1'b0, 1'b0});
      end
      pcm  = pcm16_of(bits);
      ends = ({1'b0, done_q} + 32'd1) >= {1'b0, total_q};
      wav_expect.push_back('{pcm[7:0], 1'b0, 1'b0});
      wav_expect.push_back('{pcm[15:8], 1'b1, ends});
      done_q = ends ? 31'd0 : done_q + 31'd1;
   endtask

   // Driver: present queued samples at the falling edge, with random gaps, and stall rsp_tready at random.
   always @(negedge clock) begin
      if (!reset) begin
         if (!(req_tvalid && !req_tready_s)) begin
            if (src_gap > 0) begin
               src_gap <= src_gap - 1;
               req_tvalid <= 1'b0;
            end else if (sample_fifo.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= sample_fifo.pop_front();
               if (!quiet && $urandom_range(0, 5) == 0) src_gap <= $urandom_range(1, 7);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         if (snk_gap > 0) begin
            snk_gap <= snk_gap - 1;
            rsp_tready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            snk_gap <= $urandom_range(0, 6);
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Monitor: sample handshakes at the rising edge.
   always @(posedge clock) begin
      wav_byte_type want;
      if (reset) begin
         req_tready_s <= 1'b0;
      end else begin
         req_tready_s <= req_tready;
         if (req_tvalid && req_tready) begin
            predict_sample(req_tdata);
            samples_sent++;
            idle_cycles = 0;
         end
         if (rsp_tvalid && rsp_tready) begin
            idle_cycles = 0;
            bytes_seen++;
            if (wav_expect.size() == 0) begin
               $display("%0t: unexpected byte %h last %b file_last %b", $time,
                        rsp_tdata, rsp_tlast, rsp_tuser);
               errors++;
            end else begin
               want = wav_expect.pop_front();
               if (rsp_tuser) files_seen++;
               if (want.wav_byte !== rsp_tdata || want.run_last !== rsp_tlast ||
                   want.file_last !== rsp_tuser) begin
                  $display("%0t: mismatch expected byte %h last %b file_last %b, got %h %b %b",
                           $time, want.wav_byte, want.run_last, want.file_last,
                           rsp_tdata, rsp_tlast, rsp_tuser);
                  errors++;
               end
            end
         end
         if (csr_valid && csr_ready) idle_cycles = 0;
         idle_cycles++;
         if (idle_cycles > 2000) begin
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // Hand a sample to the driver and wait until it has been taken.
   task automatic send_sample(input logic [31:0] bits);
      int target;
      target = samples_sent + sample_fifo.size() + 1;
      sample_fifo.push_back(bits);
      while (samples_sent < target) @(posedge clock);
   endtask

   // Wait for every owed byte and queued sample, then let anything in flight settle.
   task automatic drain();
      while (wav_expect.size() > 0 || sample_fifo.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Register write while the block is idle.
   task automatic csr_write(input logic idx, input logic [30:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == wavf_pkg::CsrRate) rate_q = val;
      else total_q = val;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic logic [31:0] rand_sample();
      case ($urandom_range(0, 9))
         0: return $urandom();                                      // any pattern
         1: return {1'($urandom_range(0, 1)), 8'hff, 23'($urandom())}; // NaN / inf
         2: return {1'($urandom_range(0, 1)), 8'($urandom_range(127, 160)),
                    23'($urandom())};
         3: return {1'($urandom_range(0, 1)), 8'($urandom_range(0, 5)),
                    23'($urandom())};
         default: return {1'($urandom_range(0, 1)), 8'($urandom_range(100, 126)),
                          23'($urandom())};                           // in range
      endcase
   endfunction

   initial begin
      logic [31:0] directed[$];
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: zeros, unit values, clipping, non-finite, half-step rounding.
      directed = '{32'h0000_0000, 32'h8000_0000, 32'h3f80_0000, 32'hbf80_0000,
                   32'h4000_0000, 32'hc2c8_0000, 32'h7f80_0000, 32'hff80_0000,
                   32'h7fc0_0000, 32'hffff_ffff, 32'h3f00_0000, 32'hbf00_0000,
                   32'h3800_0100, 32'h0000_0001, 32'h7f7f_ffff, 32'h3effffff};
      foreach (directed[k]) send_sample(directed[k]);
      drain();
      csr_write(wavf_pkg::CsrTotal, 31'd3);
      csr_write(wavf_pkg::CsrRate, 31'h7fff_ffff);
      for (int k = 0; k < 5; k++) send_sample(rand_sample());
      drain();                                  // sender holds until all bytes are in
      csr_write(wavf_pkg::CsrTotal, 31'd1);     // lowered mid-file: next sample ends it
      send_sample(32'h3e80_0000);
      drain();
      csr_write(wavf_pkg::CsrTotal, 31'd0);
      csr_write(wavf_pkg::CsrRate, 31'd0);
      send_sample(32'h3f40_0000);
      send_sample(32'hbf40_0000);
      drain();
      csr_write(wavf_pkg::CsrTotal, 31'h7fff_ffff);
      csr_write(wavf_pkg::CsrRate, 31'd1);
      send_sample(32'h3c00_0000);
      drain();

      // Random phases with varied register settings.
      for (int ph = 0; ph < 6; ph++) begin
         csr_write(wavf_pkg::CsrRate,
                   (ph % 3 == 0) ? 31'($urandom()) : 31'($urandom_range(1, 96000)));
         csr_write(wavf_pkg::CsrTotal, 31'($urandom_range(1, 9)));
         if (ph == 5) quiet = 1'b1;
         for (int k = 0; k < 22; k++) sample_fifo.push_back(rand_sample());
         drain();
      end
      csr_write(wavf_pkg::CsrTotal, 31'h7fff_ffed);
      csr_write(wavf_pkg::CsrRate, 31'd44100);
      drain();

      $display("Covered %0d samples, %0d bytes, %0d completed files,", samples_sent,
               bytes_seen, files_seen);
      $display("with clipping, non-finite inputs and register extremes.");
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end
endmodule
